FILE: rtl/jads_pkg.sv
// ============================================================================
// jads_pkg: shared types and constants for the axis dead-zone scaler
// Widths, register codes, reset values and the beat structs that travel
// between the pipeline stages.
// ============================================================================
package jads_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 12;
    localparam int CFG_BITS    = 12;
    localparam int MV_BITS     = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int MV_SBITS    = MV_BITS + 1;
    localparam int INV_BITS    = 2;
    localparam int CHAN_BITS   = 3;
    localparam int VALUE_BITS  = 16;

    // scaling and divider geometry
    localparam int FULL_SCALE  = 32767;
    localparam int SCALE_BITS  = 15;
    localparam int NUM_BITS    = MV_BITS + SCALE_BITS;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = (NUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUOT_BITS   = DIV_STAGES * DIV_STEPS;

    // channel codes
    localparam logic [CHAN_BITS-1:0] CHAN_LX         = 3'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_LY         = 3'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_LAST_STICK = 3'd3;
    localparam logic [CHAN_BITS-1:0] CHAN_LAST       = 3'd5;

    // register indexes
    typedef enum logic [2:0] {
        REG_STICK_MIN = 3'd0,
        REG_STICK_MAX = 3'd1,
        REG_DEAD_LOW  = 3'd2,
        REG_DEAD_HIGH = 3'd3,
        REG_TRIG_MIN  = 3'd4,
        REG_TRIG_MAX  = 3'd5,
        REG_INVERT    = 3'd6
    } cfg_idx_t;

    // register reset values
    localparam logic [CFG_BITS-1:0] RST_STICK_MIN = 12'd250;
    localparam logic [CFG_BITS-1:0] RST_STICK_MAX = 12'd1550;
    localparam logic [CFG_BITS-1:0] RST_DEAD_LOW  = 12'd790;
    localparam logic [CFG_BITS-1:0] RST_DEAD_HIGH = 12'd1010;
    localparam logic [CFG_BITS-1:0] RST_TRIG_MIN  = 12'd50;
    localparam logic [CFG_BITS-1:0] RST_TRIG_MAX  = 12'd800;
    localparam logic [INV_BITS-1:0] RST_INVERT    = 2'd0;

    // calibration set handed to the front stage
    typedef struct packed {
        logic [CFG_BITS-1:0] stick_min;
        logic [CFG_BITS-1:0] stick_max;
        logic [CFG_BITS-1:0] dead_low;
        logic [CFG_BITS-1:0] dead_high;
        logic [CFG_BITS-1:0] trigger_floor;
        logic [CFG_BITS-1:0] trigger_ceil;
        logic [INV_BITS-1:0] invert;
    } cfg_t;

    // beat after clamp and zone select
    typedef struct packed {
        logic [CHAN_BITS-1:0]       chan;
        logic signed [MV_BITS:0]    offset;
        logic signed [MV_BITS:0]    span;
        logic                       zero;
        logic                       negate;
        logic                       trig;
    } front_t;

    // beat inside the divider
    typedef struct packed {
        logic [CHAN_BITS-1:0]  chan;
        logic [MV_BITS-1:0]    rem;
        logic [QUOT_BITS-1:0]  num;
        logic [MV_BITS-1:0]    divisor;
        logic [QUOT_BITS-1:0]  quot;
        logic                  qneg;
        logic                  zero;
        logic                  negate;
        logic                  trig;
    } div_t;

    // widen an unsigned millivolt value to the signed working width
    function automatic logic signed [MV_BITS:0] ext_cfg(input logic [CFG_BITS-1:0] x);
        return $signed(MV_SBITS'(x));
    endfunction

    function automatic logic signed [MV_BITS:0] ext_sample(input logic [SAMPLE_BITS-1:0] x);
        return $signed(MV_SBITS'(x));
    endfunction

endpackage

FILE: rtl/jads_front.sv
// ============================================================================
// jads_front: clamp and zone select stage
// Clamps the sample to the calibration range, picks the dead zone side and
// forms the signed offset and span for the scaling step.
// ============================================================================
module jads_front
    import jads_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    input  logic [CHAN_BITS-1:0]   channel,
    input  logic [SAMPLE_BITS-1:0] sample_mv,
    input  logic                   read_failed,
    input  cfg_t                   cfg,
    output logic                   up_ready,
    input  logic                   dn_ready,
    output logic                   dn_valid,
    output front_t                 dn_data
);

    logic                    v_reg;
    front_t                  d_reg;
    front_t                  d_next;
    logic                    keep;
    logic signed [MV_BITS:0] mv;
    logic signed [MV_BITS:0] lo;
    logic signed [MV_BITS:0] hi;
    logic signed [MV_BITS:0] dzl;
    logic signed [MV_BITS:0] dzh;
    logic signed [MV_BITS:0] raised;
    logic signed [MV_BITS:0] clamped;
    logic                    trig;
    logic                    below;
    logic                    in_zone;

    // failed reads and unused channels are taken and dropped here
    assign keep = !read_failed && (channel <= CHAN_LAST);

    // clamp: raise to the floor first, then lower to the ceiling
    always_comb
    begin
        trig    = channel > CHAN_LAST_STICK;
        mv      = ext_sample(sample_mv);
        lo      = trig ? ext_cfg(cfg.trigger_floor) : ext_cfg(cfg.stick_min);
        hi      = trig ? ext_cfg(cfg.trigger_ceil) : ext_cfg(cfg.stick_max);
        dzl     = ext_cfg(cfg.dead_low);
        dzh     = ext_cfg(cfg.dead_high);
        raised  = (mv < lo) ? lo : mv;
        clamped = (raised > hi) ? hi : raised;
        below   = clamped < dzl;
        in_zone = !below && (clamped <= dzh);
    end

    // offset and span for the selected segment
    always_comb
    begin
        d_next.chan   = channel;
        d_next.trig   = trig;
        d_next.negate = ((channel == CHAN_LX) && cfg.invert[0]) ||
                        ((channel == CHAN_LY) && cfg.invert[1]);
        if (trig)
        begin
            d_next.offset = clamped - lo;
            d_next.span   = hi - lo;
        end
        else if (below)
        begin
            d_next.offset = clamped - dzl;
            d_next.span   = dzl - lo;
        end
        else
        begin
            d_next.offset = clamped - dzh;
            d_next.span   = hi - dzh;
        end
        d_next.zero = (!trig && in_zone) || (d_next.span == '0);
    end

    // stage register
    assign up_ready = !v_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid && keep;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

FILE: rtl/jads_mul.sv
// ============================================================================
// jads_mul: dividend stage
// Splits offset and span into magnitudes and sign, and multiplies the
// offset magnitude by full scale to form the dividend.
// ============================================================================
module jads_mul
    import jads_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  front_t up_data,
    output logic   up_ready,
    input  logic   dn_ready,
    output logic   dn_valid,
    output div_t   dn_data
);

    logic                    v_reg;
    div_t                    d_reg;
    div_t                    d_next;
    logic signed [MV_BITS:0] off_abs;
    logic signed [MV_BITS:0] span_abs;
    logic [MV_BITS-1:0]      off_mag;
    logic [NUM_BITS-1:0]     prod;

    // magnitudes fit in MV_BITS since both ends are below 2**MV_BITS
    always_comb
    begin
        off_abs  = up_data.offset[MV_BITS] ? -up_data.offset : up_data.offset;
        span_abs = up_data.span[MV_BITS] ? -up_data.span : up_data.span;
        off_mag  = off_abs[MV_BITS-1:0];
        prod     = {{SCALE_BITS{1'b0}}, off_mag} *
                   {{MV_BITS{1'b0}}, SCALE_BITS'(FULL_SCALE)};
    end

    always_comb
    begin
        d_next.chan    = up_data.chan;
        d_next.rem     = '0;
        d_next.num     = QUOT_BITS'(prod);
        d_next.divisor = span_abs[MV_BITS-1:0];
        d_next.quot    = '0;
        d_next.qneg    = up_data.offset[MV_BITS] ^ up_data.span[MV_BITS];
        d_next.zero    = up_data.zero;
        d_next.negate  = up_data.negate;
        d_next.trig    = up_data.trig;
    end

    // stage register
    assign up_ready = !v_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

FILE: rtl/jads_div_stage.sv
// ============================================================================
// jads_div_stage: one slice of the pipelined divider
// Runs a few restoring division steps on magnitudes and shifts the
// resulting quotient bits in.
// ============================================================================
module jads_div_stage
    import jads_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  div_t up_data,
    output logic up_ready,
    input  logic dn_ready,
    output logic dn_valid,
    output div_t dn_data
);

    logic v_reg;
    div_t d_reg;
    div_t d_next;

    // restoring steps, one quotient bit each
    always_comb
    begin
        logic [MV_BITS-1:0]   r;
        logic [QUOT_BITS-1:0] n;
        logic [QUOT_BITS-1:0] q;
        logic [MV_BITS:0]     sh;
        r = up_data.rem;
        n = up_data.num;
        q = up_data.quot;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            sh = {r, n[QUOT_BITS-1]};
            n  = {n[QUOT_BITS-2:0], 1'b0};
            q  = {q[QUOT_BITS-2:0], 1'b0};
            if (sh >= {1'b0, up_data.divisor})
            begin
                sh   = sh - {1'b0, up_data.divisor};
                q[0] = 1'b1;
            end
            r = sh[MV_BITS-1:0];
        end
        d_next      = up_data;
        d_next.rem  = r;
        d_next.num  = n;
        d_next.quot = q;
    end

    // stage register
    assign up_ready = !v_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    // partial remainder stays below a nonzero divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && (d_reg.divisor != '0) |-> d_reg.rem < d_reg.divisor)
        else $error("divider remainder not below divisor");

endmodule

FILE: rtl/jads_out.sv
// ============================================================================
// jads_out: sign, saturate and output register
// Applies quotient sign and axis inversion, clamps to the axis range and
// holds the result beat for the consumer.
// ============================================================================
module jads_out
    import jads_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    input  div_t                         up_data,
    output logic                         up_ready,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [CHAN_BITS-1:0]         axis_channel,
    output logic signed [VALUE_BITS-1:0] axis_value
);

    logic                    v_reg;
    logic [CHAN_BITS-1:0]    chan_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [VALUE_BITS-1:0]   value_next;
    logic [SCALE_BITS-1:0]   sat;
    logic [VALUE_BITS-1:0]   mag;
    logic                    flip;

    // saturate the magnitude, then apply sign
    always_comb
    begin
        sat  = (up_data.quot > QUOT_BITS'(FULL_SCALE)) ? SCALE_BITS'(FULL_SCALE)
                                                       : up_data.quot[SCALE_BITS-1:0];
        mag  = VALUE_BITS'(sat);
        flip = up_data.qneg ^ up_data.negate;
        if (up_data.zero)
            value_next = '0;
        else if (up_data.trig)
            value_next = up_data.qneg ? '0 : mag;
        else
            value_next = flip ? -mag : mag;
    end

    // output register
    assign up_ready = !v_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            chan_reg  <= up_data.chan;
            value_reg <= value_next;
        end
    end

    assign out_valid    = v_reg;
    assign axis_channel = chan_reg;
    assign axis_value   = $signed(value_reg);

endmodule

FILE: rtl/joystick_axis_deadzone_scaler_top.sv
// ============================================================================
// joystick_axis_deadzone_scaler_top: stick and trigger axis mapper
// Calibration registers, front clamp stage, dividend stage, pipelined
// divider and output stage.
// ============================================================================
// Each beat passes the registered front, dividend, divider slice and output
// stages in that order (seven divider slices with 12-bit samples).
// Throughput: one beat per cycle while the output is not stalled; the divider
// retires four quotient bits per slice, so every slice can take a new beat each cycle.
// Reset clears all stage valid bits and loads the calibration registers with
// their default values; a failed read or unused channel yields no result beat.
module joystick_axis_deadzone_scaler_top
    import jads_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CHAN_BITS-1:0]         channel,
    input  logic [SAMPLE_BITS-1:0]       sample_mv,
    input  logic                         read_failed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [CHAN_BITS-1:0]         axis_channel,
    output logic signed [VALUE_BITS-1:0] axis_value
);

    cfg_t   cfg_reg;
    logic   front_ready;
    logic   front_valid;
    front_t front_data;
    logic   mul_ready;
    logic   div_valid [DIV_STAGES+1];
    logic   div_ready [DIV_STAGES+1];
    div_t   div_data  [DIV_STAGES+1];

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_min     <= RST_STICK_MIN;
            cfg_reg.stick_max     <= RST_STICK_MAX;
            cfg_reg.dead_low      <= RST_DEAD_LOW;
            cfg_reg.dead_high     <= RST_DEAD_HIGH;
            cfg_reg.trigger_floor <= RST_TRIG_MIN;
            cfg_reg.trigger_ceil  <= RST_TRIG_MAX;
            cfg_reg.invert        <= RST_INVERT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_STICK_MIN: cfg_reg.stick_min     <= cfg_data;
                REG_STICK_MAX: cfg_reg.stick_max     <= cfg_data;
                REG_DEAD_LOW:  cfg_reg.dead_low      <= cfg_data;
                REG_DEAD_HIGH: cfg_reg.dead_high     <= cfg_data;
                REG_TRIG_MIN:  cfg_reg.trigger_floor <= cfg_data;
                REG_TRIG_MAX:  cfg_reg.trigger_ceil  <= cfg_data;
                REG_INVERT:    cfg_reg.invert        <= cfg_data[INV_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // clamp and zone select
    jads_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .channel     (channel),
        .sample_mv   (sample_mv),
        .read_failed (read_failed),
        .cfg         (cfg_reg),
        .up_ready    (front_ready),
        .dn_ready    (mul_ready),
        .dn_valid    (front_valid),
        .dn_data     (front_data)
    );

    assign in_stall = !front_ready;

    // dividend
    jads_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_data  (front_data),
        .up_ready (mul_ready),
        .dn_ready (div_ready[0]),
        .dn_valid (div_valid[0]),
        .dn_data  (div_data[0])
    );

    // divider slices
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        jads_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[k]),
            .up_data  (div_data[k]),
            .up_ready (div_ready[k]),
            .dn_ready (div_ready[k+1]),
            .dn_valid (div_valid[k+1]),
            .dn_data  (div_data[k+1])
        );
    end

    // sign, saturate, output beat
    jads_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (div_valid[DIV_STAGES]),
        .up_data      (div_data[DIV_STAGES]),
        .up_ready     (div_ready[DIV_STAGES]),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .axis_channel (axis_channel),
        .axis_value   (axis_value)
    );

    // input backs up only when every stage holds a beat behind a stalled output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the pipeline has room");

    // trigger beats are never negative
    a_trig_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (axis_channel > CHAN_LAST_STICK) |-> !axis_value[VALUE_BITS-1])
        else $error("negative trigger value");

    // result stays within the symmetric axis range and on a used channel
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_value != {1'b1, {(VALUE_BITS-1){1'b0}}}) &&
                      (axis_channel <= CHAN_LAST))
        else $error("result beat out of range");

endmodule
